// ===== design/rsm_pkg.sv =====
package rsm_pkg;

    // widths fixed by the record format
    localparam int CNT_W   = 16;
    localparam int COORD_W = 16;
    localparam int DELTA_W = COORD_W + 1;
    localparam int PART_W  = 32;
    localparam int NSUM    = 5;

    // moved sums stay below 2^51 in magnitude
    localparam int MOVED_W = 56;

    // shared multiplier operand and product widths
    localparam int SQ_W   = 2 * DELTA_W;
    localparam int OPA_W  = DELTA_W + 1;
    localparam int OPB_W  = SQ_W + 1;
    localparam int PROD_W = OPA_W + OPB_W;

    // defaults for top level parameters
    localparam int SUM_WIDTH_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // register map
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;
    localparam int DATA_W    = 32;
    localparam logic [REG_IDX_W-1:0] REG_BASE_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BASE_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 2'd2;
    localparam logic [CNT_W-1:0]     LIMIT_RESET = 16'h00FF;
    localparam logic [CNT_W-1:0]     CNT_MAX     = 16'hFFFF;

    // lane numbering of the five sums
    localparam int LANE_X  = 0;
    localparam int LANE_Y  = 1;
    localparam int LANE_XX = 2;
    localparam int LANE_YY = 3;
    localparam int LANE_XY = 4;

    // partial record after delta computation
    typedef struct packed {
        logic [CNT_W-1:0]          n;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [PART_W-1:0]  sx;
        logic signed [PART_W-1:0]  sy;
        logic signed [PART_W-1:0]  sxx;
        logic signed [PART_W-1:0]  syy;
        logic signed [PART_W-1:0]  sxy;
    } part_t;

    // record moved onto the accumulator base
    typedef struct packed {
        logic [CNT_W-1:0]          n;
        logic signed [MOVED_W-1:0] mx;
        logic signed [MOVED_W-1:0] my;
        logic signed [MOVED_W-1:0] mxx;
        logic signed [MOVED_W-1:0] myy;
        logic signed [MOVED_W-1:0] mxy;
    } moved_t;

endpackage

// ===== design/regression_sum_merge.sv =====
// Regression sum merge: folds partial regression records (count, base point,
// five delta sums) into one accumulator kept against a configured base point.
// Input beats arrive on the s_ valid/ready channel; one result beat per input
// leaves on the m_ channel, showing merged (0 when a sum would leave the
// symmetric signed SUM_WIDTH range) and the accumulator count and sums
// after the step. The APB port sets base_x, base_y and small_count_limit;
// write only while no beat is in flight.
// In the mover, the twelve products of an item run on a single shared
// 18x35 multiplier, one at a time, followed by drain and handoff; the mover
// takes no new item until its result is taken. The merge stage then does
// add, divide and commit.
// A front holding register and a small queue take new beats while the mover
// and merge are busy, so the input keeps flowing until the queue fills.
// A stalled result beat holds the merge stage; the accumulator does not move
// until it is taken, and back pressure reaches s_ready through the queue.
// Reset clears the accumulator to zero, base to 0 and the limit to 255.
module regression_sum_merge #(
    parameter int SUM_WIDTH   = rsm_pkg::SUM_WIDTH_DEF,
    parameter int QUEUE_DEPTH = rsm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsm_pkg::ADDR_W-1:0]          paddr,
    input  logic [rsm_pkg::DATA_W-1:0]          pwdata,
    output logic [rsm_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rsm_pkg::CNT_W-1:0]           s_part_count,
    input  logic signed [rsm_pkg::COORD_W-1:0]  s_part_base_x,
    input  logic signed [rsm_pkg::COORD_W-1:0]  s_part_base_y,
    input  logic signed [rsm_pkg::PART_W-1:0]   s_part_sum_dx,
    input  logic signed [rsm_pkg::PART_W-1:0]   s_part_sum_dy,
    input  logic signed [rsm_pkg::PART_W-1:0]   s_part_sum_dxx,
    input  logic signed [rsm_pkg::PART_W-1:0]   s_part_sum_dyy,
    input  logic signed [rsm_pkg::PART_W-1:0]   s_part_sum_dxy,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_merged,
    output logic [rsm_pkg::CNT_W-1:0]           m_total_count,
    output logic signed [SUM_WIDTH-1:0]         m_total_sum_dx,
    output logic signed [SUM_WIDTH-1:0]         m_total_sum_dy,
    output logic signed [SUM_WIDTH-1:0]         m_total_sum_dxx,
    output logic signed [SUM_WIDTH-1:0]         m_total_sum_dyy,
    output logic signed [SUM_WIDTH-1:0]         m_total_sum_dxy
);

    localparam int CW = rsm_pkg::COORD_W;
    localparam int NW = rsm_pkg::CNT_W;
    localparam int DW = rsm_pkg::DATA_W;

    logic signed [CW-1:0]              base_x_reg;
    logic signed [CW-1:0]              base_y_reg;
    logic [NW-1:0]                     limit_reg;
    logic                              cfg_wr;
    logic [rsm_pkg::REG_IDX_W-1:0]     cfg_idx;

    logic                              fq_valid;
    logic                              fq_ready;
    rsm_pkg::part_t                    fq_item;
    logic                              qm_valid;
    logic                              qm_ready;
    rsm_pkg::part_t                    qm_item;
    logic                              mm_valid;
    logic                              mm_ready;
    rsm_pkg::moved_t                   mm_data;

    // register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[rsm_pkg::ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_x_reg <= '0;
            base_y_reg <= '0;
            limit_reg  <= rsm_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                rsm_pkg::REG_BASE_X: base_x_reg <= pwdata[CW-1:0];
                rsm_pkg::REG_BASE_Y: base_y_reg <= pwdata[CW-1:0];
                rsm_pkg::REG_LIMIT:  limit_reg  <= pwdata[NW-1:0];
                default: begin
                    limit_reg <= limit_reg;
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (cfg_idx)
            rsm_pkg::REG_BASE_X: prdata = {{(DW - CW){1'b0}}, base_x_reg};
            rsm_pkg::REG_BASE_Y: prdata = {{(DW - CW){1'b0}}, base_y_reg};
            rsm_pkg::REG_LIMIT:  prdata = {{(DW - NW){1'b0}}, limit_reg};
            default:             prdata = '0;
        endcase
    end

    // front: takes beats and forms base offsets
    rsm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_part_count   (s_part_count),
        .s_part_base_x  (s_part_base_x),
        .s_part_base_y  (s_part_base_y),
        .s_part_sum_dx  (s_part_sum_dx),
        .s_part_sum_dy  (s_part_sum_dy),
        .s_part_sum_dxx (s_part_sum_dxx),
        .s_part_sum_dyy (s_part_sum_dyy),
        .s_part_sum_dxy (s_part_sum_dxy),
        .base_x         (base_x_reg),
        .base_y         (base_y_reg),
        .q_valid        (fq_valid),
        .q_ready        (fq_ready),
        .q_item         (fq_item)
    );

    // queue between front and back
    rsm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qm_valid),
        .out_ready (qm_ready),
        .out_item  (qm_item)
    );

    // back: move record onto accumulator base
    rsm_mover u_mover (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (qm_valid),
        .in_ready  (qm_ready),
        .in_item   (qm_item),
        .out_valid (mm_valid),
        .out_ready (mm_ready),
        .out_data  (mm_data)
    );

    // back: scale, range check and accumulate
    rsm_merge #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_merge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (mm_valid),
        .in_ready        (mm_ready),
        .in_data         (mm_data),
        .limit           (limit_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_merged        (m_merged),
        .m_total_count   (m_total_count),
        .m_total_sum_dx  (m_total_sum_dx),
        .m_total_sum_dy  (m_total_sum_dy),
        .m_total_sum_dxx (m_total_sum_dxx),
        .m_total_sum_dyy (m_total_sum_dyy),
        .m_total_sum_dxy (m_total_sum_dxy)
    );

endmodule

// ===== design/rsm_front.sv =====
module rsm_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rsm_pkg::CNT_W-1:0]           s_part_count,
    input  logic signed [rsm_pkg::COORD_W-1:0]  s_part_base_x,
    input  logic signed [rsm_pkg::COORD_W-1:0]  s_part_base_y,
    input  logic signed [rsm_pkg::PART_W-1:0]   s_part_sum_dx,
    input  logic signed [rsm_pkg::PART_W-1:0]   s_part_sum_dy,
    input  logic signed [rsm_pkg::PART_W-1:0]   s_part_sum_dxx,
    input  logic signed [rsm_pkg::PART_W-1:0]   s_part_sum_dyy,
    input  logic signed [rsm_pkg::PART_W-1:0]   s_part_sum_dxy,
    input  logic signed [rsm_pkg::COORD_W-1:0]  base_x,
    input  logic signed [rsm_pkg::COORD_W-1:0]  base_y,
    output logic                                q_valid,
    input  logic                                q_ready,
    output rsm_pkg::part_t                      q_item
);

    logic           hold_valid_reg;
    rsm_pkg::part_t hold_reg;
    logic           accept;

    assign s_ready = !hold_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;
    assign q_valid = hold_valid_reg;
    assign q_item  = hold_reg;

    // beat holding flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (accept) begin
            hold_valid_reg <= 1'b1;
        end else if (q_ready) begin
            hold_valid_reg <= 1'b0;
        end
    end

    // base offsets of the record against the accumulator base
    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_reg.n   <= s_part_count;
            hold_reg.dx  <= {base_x[rsm_pkg::COORD_W-1], base_x}
                          - {s_part_base_x[rsm_pkg::COORD_W-1], s_part_base_x};
            hold_reg.dy  <= {base_y[rsm_pkg::COORD_W-1], base_y}
                          - {s_part_base_y[rsm_pkg::COORD_W-1], s_part_base_y};
            hold_reg.sx  <= s_part_sum_dx;
            hold_reg.sy  <= s_part_sum_dy;
            hold_reg.sxx <= s_part_sum_dxx;
            hold_reg.syy <= s_part_sum_dyy;
            hold_reg.sxy <= s_part_sum_dxy;
        end
    end

endmodule

// ===== design/rsm_fifo.sv =====
module rsm_fifo #(
    parameter int DEPTH = rsm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  rsm_pkg::part_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output rsm_pkg::part_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rsm_pkg::part_t   mem_reg [DEPTH];
    rsm_pkg::part_t   rd_data_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             push;
    logic             pop;

    assign in_ready  = cnt_reg != CNT_W'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = rd_data_reg;

    // read pointer after this cycle's pop
    assign rd_ptr_next = pop ? ((rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1)
                             : rd_ptr_reg;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            rd_ptr_reg <= rd_ptr_next;
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // entry storage and head entry read, with bypass of a beat written to the head
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
        if (push && (wr_ptr_reg == rd_ptr_next)) begin
            rd_data_reg <= in_item;
        end else begin
            rd_data_reg <= mem_reg[rd_ptr_next];
        end
    end

endmodule

// ===== design/rsm_mover.sv =====
module rsm_mover (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  rsm_pkg::part_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output rsm_pkg::moved_t out_data
);

    localparam int MW = rsm_pkg::MOVED_W;
    localparam int PW = rsm_pkg::PROD_W;
    localparam int AW = rsm_pkg::OPA_W;
    localparam int BW = rsm_pkg::OPB_W;
    localparam int QW = rsm_pkg::SQ_W;
    localparam int DW = rsm_pkg::DELTA_W;
    localparam int SW = rsm_pkg::PART_W;
    localparam int NW = rsm_pkg::CNT_W;

    // product schedule
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_DXDX = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DYDY = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DXDY = 4'd2;
    localparam logic [STEP_W-1:0] STEP_NDX  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_NDY  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_NXX  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_NYY  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_NXY  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DXSX = 4'd8;
    localparam logic [STEP_W-1:0] STEP_DYSY = 4'd9;
    localparam logic [STEP_W-1:0] STEP_DXSY = 4'd10;
    localparam logic [STEP_W-1:0] STEP_DYSX = 4'd11;
    localparam logic [STEP_W-1:0] STEP_END  = 4'd12;

    typedef enum logic [3:0] {
        OP_PXX, OP_PYY, OP_PXY, OP_MX, OP_MY,
        OP_MXX, OP_MYY, OP_MXY, OP_MXX2, OP_MYY2
    } op_t;

    typedef enum logic [2:0] {
        MV_IDLE = 3'b001,
        MV_RUN  = 3'b010,
        MV_DONE = 3'b100
    } mv_state_t;

    mv_state_t              state_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   prod_valid_reg;
    op_t                    prod_op_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [QW-1:0]   pxx_reg;
    logic signed [QW-1:0]   pyy_reg;
    logic signed [QW-1:0]   pxy_reg;
    rsm_pkg::part_t         item_reg;
    rsm_pkg::moved_t        moved_reg;

    logic signed [AW-1:0]   a_op;
    logic signed [BW-1:0]   b_op;
    op_t                    op;
    logic signed [PW-1:0]   prod;
    logic signed [MW-1:0]   prod_ext;
    logic signed [AW-1:0]   a_dx;
    logic signed [AW-1:0]   a_dy;
    logic signed [AW-1:0]   a_n;
    logic signed [BW-1:0]   b_dx;
    logic signed [BW-1:0]   b_dy;
    logic signed [BW-1:0]   b_sx;
    logic signed [BW-1:0]   b_sy;

    assign in_ready  = state_reg == MV_IDLE;
    assign out_valid = state_reg == MV_DONE;
    assign out_data  = moved_reg;

    // operand candidates, sign or zero extended
    assign a_dx = {{(AW - DW){item_reg.dx[DW-1]}}, item_reg.dx};
    assign a_dy = {{(AW - DW){item_reg.dy[DW-1]}}, item_reg.dy};
    assign a_n  = {{(AW - NW){1'b0}}, item_reg.n};
    assign b_dx = {{(BW - DW){item_reg.dx[DW-1]}}, item_reg.dx};
    assign b_dy = {{(BW - DW){item_reg.dy[DW-1]}}, item_reg.dy};
    assign b_sx = {{(BW - SW){item_reg.sx[SW-1]}}, item_reg.sx};
    assign b_sy = {{(BW - SW){item_reg.sy[SW-1]}}, item_reg.sy};

    // operand selection per step
    always_comb begin
        a_op = '0;
        b_op = '0;
        op   = OP_MX;
        case (step_reg)
            STEP_DXDX: begin a_op = a_dx; b_op = b_dx; op = OP_PXX;  end
            STEP_DYDY: begin a_op = a_dy; b_op = b_dy; op = OP_PYY;  end
            STEP_DXDY: begin a_op = a_dx; b_op = b_dy; op = OP_PXY;  end
            STEP_NDX:  begin a_op = a_n;  b_op = b_dx; op = OP_MX;   end
            STEP_NDY:  begin a_op = a_n;  b_op = b_dy; op = OP_MY;   end
            STEP_NXX: begin
                a_op = a_n;
                b_op = {pxx_reg[QW-1], pxx_reg};
                op   = OP_MXX;
            end
            STEP_NYY: begin
                a_op = a_n;
                b_op = {pyy_reg[QW-1], pyy_reg};
                op   = OP_MYY;
            end
            STEP_NXY: begin
                a_op = a_n;
                b_op = {pxy_reg[QW-1], pxy_reg};
                op   = OP_MXY;
            end
            STEP_DXSX: begin a_op = a_dx; b_op = b_sx; op = OP_MXX2; end
            STEP_DYSY: begin a_op = a_dy; b_op = b_sy; op = OP_MYY2; end
            STEP_DXSY: begin a_op = a_dx; b_op = b_sy; op = OP_MXY;  end
            STEP_DYSX: begin a_op = a_dy; b_op = b_sx; op = OP_MXY;  end
            default: begin
                a_op = '0;
                b_op = '0;
                op   = OP_MX;
            end
        endcase
    end

    // shared multiplier
    assign prod     = a_op * b_op;
    assign prod_ext = {{(MW - PW){prod_reg[PW-1]}}, prod_reg};

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= MV_IDLE;
            step_reg       <= '0;
            prod_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                MV_IDLE: begin
                    prod_valid_reg <= 1'b0;
                    if (in_valid) begin
                        step_reg  <= STEP_DXDX;
                        state_reg <= MV_RUN;
                    end
                end
                MV_RUN: begin
                    if (step_reg != STEP_END) begin
                        prod_valid_reg <= 1'b1;
                        step_reg       <= step_reg + 1'b1;
                    end else begin
                        prod_valid_reg <= 1'b0;
                        if (!prod_valid_reg) begin
                            state_reg <= MV_DONE;
                        end
                    end
                end
                MV_DONE: begin
                    if (out_ready) begin
                        state_reg <= MV_IDLE;
                    end
                end
                default: begin
                    state_reg <= MV_IDLE;
                end
            endcase
        end
    end

    // product register and accumulation of moved sums
    always_ff @(posedge aclk) begin
        if (state_reg == MV_RUN) begin
            prod_reg    <= prod;
            prod_op_reg <= op;
        end
        if (state_reg == MV_IDLE && in_valid) begin
            item_reg      <= in_item;
            moved_reg.n   <= in_item.n;
            moved_reg.mx  <= {{(MW - SW){in_item.sx[SW-1]}}, in_item.sx};
            moved_reg.my  <= {{(MW - SW){in_item.sy[SW-1]}}, in_item.sy};
            moved_reg.mxx <= {{(MW - SW){in_item.sxx[SW-1]}}, in_item.sxx};
            moved_reg.myy <= {{(MW - SW){in_item.syy[SW-1]}}, in_item.syy};
            moved_reg.mxy <= {{(MW - SW){in_item.sxy[SW-1]}}, in_item.sxy};
        end else if (prod_valid_reg) begin
            case (prod_op_reg)
                OP_PXX:  pxx_reg <= prod_reg[QW-1:0];
                OP_PYY:  pyy_reg <= prod_reg[QW-1:0];
                OP_PXY:  pxy_reg <= prod_reg[QW-1:0];
                OP_MX:   moved_reg.mx  <= moved_reg.mx + prod_ext;
                OP_MY:   moved_reg.my  <= moved_reg.my + prod_ext;
                OP_MXX:  moved_reg.mxx <= moved_reg.mxx + prod_ext;
                OP_MYY:  moved_reg.myy <= moved_reg.myy + prod_ext;
                OP_MXY:  moved_reg.mxy <= moved_reg.mxy + prod_ext;
                OP_MXX2: moved_reg.mxx <= moved_reg.mxx + (prod_ext <<< 1);
                OP_MYY2: moved_reg.myy <= moved_reg.myy + (prod_ext <<< 1);
                default: moved_reg.mx  <= moved_reg.mx;
            endcase
        end
    end

endmodule

// ===== design/rsm_merge.sv =====
module rsm_merge #(
    parameter int SUM_WIDTH = rsm_pkg::SUM_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rsm_pkg::moved_t               in_data,
    input  logic [rsm_pkg::CNT_W-1:0]     limit,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_merged,
    output logic [rsm_pkg::CNT_W-1:0]     m_total_count,
    output logic signed [SUM_WIDTH-1:0]   m_total_sum_dx,
    output logic signed [SUM_WIDTH-1:0]   m_total_sum_dy,
    output logic signed [SUM_WIDTH-1:0]   m_total_sum_dxx,
    output logic signed [SUM_WIDTH-1:0]   m_total_sum_dyy,
    output logic signed [SUM_WIDTH-1:0]   m_total_sum_dxy
);

    localparam int MW    = rsm_pkg::MOVED_W;
    localparam int NW    = rsm_pkg::CNT_W;
    localparam int NSUM  = rsm_pkg::NSUM;
    localparam int NUM_W = (((SUM_WIDTH + 2) > MW) ? (SUM_WIDTH + 2) : MW) + 1;

    typedef enum logic [2:0] {
        MG_IDLE   = 3'b001,
        MG_DIV    = 3'b010,
        MG_COMMIT = 3'b100
    } mg_state_t;

    mg_state_t                  state_reg;
    logic                       out_valid_reg;
    logic                       merged_reg;
    logic [NW-1:0]              acc_count_reg;
    logic signed [SUM_WIDTH-1:0] acc_sum_reg [NSUM];
    logic [NW-1:0]              n_reg;
    logic                       scale_reg;
    logic signed [NUM_W-1:0]    num_reg [NSUM];
    logic signed [SUM_WIDTH-1:0] q_reg [NSUM];
    logic                       ok_reg;
    logic                       cross_reg;
    logic [NW-1:0]              cnt_new_reg;

    logic signed [MW-1:0]       moved_a [NSUM];
    logic signed [NUM_W-1:0]    num_next [NSUM];
    logic signed [SUM_WIDTH-1:0] q_next [NSUM];
    logic [NSUM-1:0]            lane_ok;
    logic signed [SUM_WIDTH-1:0] stored_next [NSUM];
    logic                       scale;
    logic [NW:0]                cnt_sum;
    logic [NW-1:0]              cnt_new;
    logic                       accept;

    assign in_ready = (state_reg == MG_IDLE) && !out_valid_reg;
    assign accept   = in_valid && in_ready;

    // result beat is the accumulator itself, stable while pending
    assign m_valid         = out_valid_reg;
    assign m_merged        = merged_reg;
    assign m_total_count   = acc_count_reg;
    assign m_total_sum_dx  = acc_sum_reg[rsm_pkg::LANE_X];
    assign m_total_sum_dy  = acc_sum_reg[rsm_pkg::LANE_Y];
    assign m_total_sum_dxx = acc_sum_reg[rsm_pkg::LANE_XX];
    assign m_total_sum_dyy = acc_sum_reg[rsm_pkg::LANE_YY];
    assign m_total_sum_dxy = acc_sum_reg[rsm_pkg::LANE_XY];

    assign moved_a[rsm_pkg::LANE_X]  = in_data.mx;
    assign moved_a[rsm_pkg::LANE_Y]  = in_data.my;
    assign moved_a[rsm_pkg::LANE_XX] = in_data.mxx;
    assign moved_a[rsm_pkg::LANE_YY] = in_data.myy;
    assign moved_a[rsm_pkg::LANE_XY] = in_data.mxy;

    // large accumulator meets small record
    assign scale = (acc_count_reg >= limit) && (in_data.n < limit);

    // saturating count and limit crossing
    assign cnt_sum = {1'b0, acc_count_reg} + {1'b0, n_reg};
    assign cnt_new = cnt_sum[NW] ? rsm_pkg::CNT_MAX : cnt_sum[NW-1:0];

    // per-sum lanes
    for (genvar k = 0; k < NSUM; k++) begin : g_lane
        localparam int SH = (k < 2) ? 1 : 2;
        localparam int DIV_M1 = (1 << SH) - 1;

        logic signed [NUM_W-1:0]     acc_ext;
        logic signed [NUM_W-1:0]     moved_ext;
        logic signed [NUM_W-1:0]     biased;
        logic signed [NUM_W-1:0]     qf;
        logic [NUM_W-SUM_WIDTH:0]    top;
        logic signed [SUM_WIDTH-1:0] cbias;
        logic signed [SUM_WIDTH-1:0] cdiv;

        // scaled accumulator plus moved sum
        assign acc_ext   = {{(NUM_W - SUM_WIDTH){acc_sum_reg[k][SUM_WIDTH-1]}},
                            acc_sum_reg[k]};
        assign moved_ext = {{(NUM_W - MW){moved_a[k][MW-1]}}, moved_a[k]};
        assign num_next[k] = (scale ? (acc_ext <<< SH) : acc_ext) + moved_ext;

        // exact division toward zero and range test
        assign biased = num_reg[k] + ((scale_reg && num_reg[k][NUM_W-1])
                        ? NUM_W'(DIV_M1) : NUM_W'(0));
        assign qf     = scale_reg ? (biased >>> SH) : biased;
        assign top    = qf[NUM_W-1:SUM_WIDTH-1];
        assign lane_ok[k] = ((&top) || !(|top))
                            && !(qf[NUM_W-1] && !(|qf[SUM_WIDTH-2:0]));
        assign q_next[k] = qf[SUM_WIDTH-1:0];

        // halving or quartering after crossing the limit
        assign cbias = q_reg[k] + (q_reg[k][SUM_WIDTH-1]
                       ? SUM_WIDTH'(DIV_M1) : SUM_WIDTH'(0));
        assign cdiv  = cbias >>> SH;
        assign stored_next[k] = cross_reg ? cdiv : q_reg[k];
    end

    // control and accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= MG_IDLE;
            out_valid_reg <= 1'b0;
            merged_reg    <= 1'b0;
            acc_count_reg <= '0;
            for (int i = 0; i < NSUM; i++) begin
                acc_sum_reg[i] <= '0;
            end
        end else begin
            if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                MG_IDLE: begin
                    if (accept) begin
                        state_reg <= MG_DIV;
                    end
                end
                MG_DIV: begin
                    state_reg <= MG_COMMIT;
                end
                MG_COMMIT: begin
                    merged_reg    <= ok_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= MG_IDLE;
                    if (ok_reg) begin
                        acc_count_reg <= cnt_new_reg;
                        for (int i = 0; i < NSUM; i++) begin
                            acc_sum_reg[i] <= stored_next[i];
                        end
                    end
                end
                default: begin
                    state_reg <= MG_IDLE;
                end
            endcase
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (accept) begin
            n_reg     <= in_data.n;
            scale_reg <= scale;
            for (int i = 0; i < NSUM; i++) begin
                num_reg[i] <= num_next[i];
            end
        end
        if (state_reg == MG_DIV) begin
            ok_reg      <= &lane_ok;
            cnt_new_reg <= cnt_new;
            cross_reg   <= (acc_count_reg < limit) && (cnt_new >= limit);
            for (int i = 0; i < NSUM; i++) begin
                q_reg[i] <= q_next[i];
            end
        end
    end

endmodule
